// ===== hdl/sswo_pkg.sv =====
// Package for the sampler state write filter.
// Holds the classified command and result word types and the state kind codes.
// No dependencies.
`default_nettype none

package sswo_pkg;

  localparam int NUM_STAGES = 21;
  localparam int ENTRY_W    = $clog2(NUM_STAGES);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;

  // State kinds and filter values.
  localparam logic [7:0]  ST_MINFILTER = 8'd6;
  localparam logic [7:0]  ST_MIPFILTER = 8'd7;
  localparam logic [7:0]  ST_MAXANISO  = 8'd10;
  localparam logic [31:0] F_POINT      = 32'd1;
  localparam logic [31:0] F_LINEAR     = 32'd2;
  localparam logic [31:0] F_ANISO      = 32'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ANISO_DEGREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRILINEAR    = 1'd1;

  // Operations decided by the front end.
  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_PASS  = 3'd1;
  localparam logic [2:0] OP_ANISO = 3'd2;
  localparam logic [2:0] OP_MIP   = 3'd3;
  localparam logic [2:0] OP_MIN   = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [ENTRY_W-1:0] entry;
    logic [31:0]        sampler;
    logic [7:0]         stype;
    logic [31:0]        value;
  } sswo_cmd_t;

  typedef struct packed {
    logic [31:0] sampler;
    logic [7:0]  stype;
    logic [31:0] value;
    logic        last;
  } sswo_res_t;

endpackage

`default_nettype wire

// ===== hdl/sswo_fifo.sv =====
// Small synchronous first-in first-out queue, generic width and depth.
// Used between front and back end and on the result side. No dependencies.
`default_nettype none

module sswo_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sswo_front.sv =====
// Front end: maps the sampler number to a shadow table entry and classifies the word.
// Depends on sswo_pkg.
`default_nettype none

module sswo_front
  import sswo_pkg::*;
(
  input  wire logic        in_push,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_sampler,
  input  wire logic [7:0]  in_state_type,
  input  wire logic [31:0] in_value,
  input  wire logic        mid_full,
  output logic             mid_push,
  output sswo_cmd_t        mid_cmd
);

  logic               mapped;
  logic [ENTRY_W-1:0] entry;

  always_comb begin
    mapped = 1'b1;
    entry  = '0;
    if (in_sampler < 32'd16) begin
      entry = in_sampler[ENTRY_W-1:0];
    end else if (in_sampler == 32'd256) begin
      entry = ENTRY_W'(16);
    end else if (in_sampler inside {[32'd257:32'd260]}) begin
      // Vertex samplers 257 to 260 have low bits 1 to 4.
      entry = ENTRY_W'(16) + ENTRY_W'(in_sampler[2:0]);
    end else begin
      mapped = 1'b0;
    end
  end

  always_comb begin
    mid_cmd.entry   = entry;
    mid_cmd.sampler = in_sampler;
    mid_cmd.stype   = in_state_type;
    mid_cmd.value   = in_value;
    if (in_cmd) begin
      mid_cmd.op = OP_RESET;
    end else if (!mapped) begin
      mid_cmd.op = OP_PASS;
    end else begin
      case (in_state_type)
        ST_MINFILTER: mid_cmd.op = OP_MIN;
        ST_MIPFILTER: mid_cmd.op = OP_MIP;
        ST_MAXANISO:  mid_cmd.op = OP_ANISO;
        default:      mid_cmd.op = OP_PASS;
      endcase
    end
  end

  assign mid_push = in_push && !mid_full;

endmodule

`default_nettype wire

// ===== hdl/sswo_back.sv =====
// Back end: shadow table, configuration registers and the result sequencer.
// Depends on sswo_pkg.
`default_nettype none

module sswo_back
  import sswo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  mid_empty,
  input  wire sswo_cmd_t             mid_cmd,
  output logic                       mid_pop,
  input  wire logic                  res_full,
  output logic                       res_push,
  output sswo_res_t                  res
);

  logic [CFG_DATA_W-1:0] degree_r;
  logic                  tri_r;
  logic [CFG_DATA_W-1:0] degree_nxt;

  logic        min_aniso_r   [NUM_STAGES];
  logic [31:0] asked_mip_r   [NUM_STAGES];
  logic [31:0] asked_aniso_r [NUM_STAGES];
  logic [31:0] sent_mip_r    [NUM_STAGES];
  logic [31:0] sent_aniso_r  [NUM_STAGES];

  logic        first_pend_r, aniso_pend_r, mip_pend_r;
  logic [31:0] smp_r, val0_r, wa_r, wm_r;
  logic [7:0]  typ_r;

  logic               busy, done_now;
  logic [ENTRY_W-1:0] e;
  logic               min_new;
  logic [31:0]        asked_a_new, asked_m_new, wa, wm, val0_nxt;

  function automatic logic [31:0] aniso_goal(input logic [CFG_DATA_W-1:0] deg,
                                             input logic min_is, input logic [31:0] asked);
    if (deg != '0 && min_is && {{(32 - CFG_DATA_W){1'b0}}, deg} > asked) begin
      return {{(32 - CFG_DATA_W){1'b0}}, deg};
    end
    return asked;
  endfunction

  function automatic logic [31:0] mip_goal(input logic trilin, input logic min_is,
                                           input logic [31:0] asked);
    if (trilin && min_is && asked == F_POINT) begin
      return F_LINEAR;
    end
    return asked;
  endfunction

  // Degree is stored normalized: one turns off, anything above sixteen clamps.
  always_comb begin
    degree_nxt = cfg_data;
    if (cfg_data == CFG_DATA_W'(1)) begin
      degree_nxt = '0;
    end else if (cfg_data > CFG_DATA_W'(16)) begin
      degree_nxt = CFG_DATA_W'(16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      tri_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANISO_DEGREE: degree_r <= degree_nxt;
        REG_TRILINEAR:    tri_r    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Result sequencer: the command word first, then re-sent anisotropy, then mip filter.
  assign busy = first_pend_r || aniso_pend_r || mip_pend_r;
  assign res_push = busy && !res_full;
  assign done_now = res_push && res.last;
  assign mid_pop = !mid_empty && (!busy || done_now);

  always_comb begin
    res.sampler = smp_r;
    if (first_pend_r) begin
      res.stype = typ_r;
      res.value = val0_r;
      res.last  = !(aniso_pend_r || mip_pend_r);
    end else if (aniso_pend_r) begin
      res.stype = ST_MAXANISO;
      res.value = wa_r;
      res.last  = !mip_pend_r;
    end else begin
      res.stype = ST_MIPFILTER;
      res.value = wm_r;
      res.last  = 1'b1;
    end
  end

  always_comb begin
    e           = mid_cmd.entry;
    min_new     = (mid_cmd.op == OP_MIN) ? (mid_cmd.value == F_ANISO) : min_aniso_r[e];
    asked_a_new = (mid_cmd.op == OP_ANISO) ? mid_cmd.value : asked_aniso_r[e];
    asked_m_new = (mid_cmd.op == OP_MIP) ? mid_cmd.value : asked_mip_r[e];
    wa          = aniso_goal(degree_r, min_new, asked_a_new);
    wm          = mip_goal(tri_r, min_new, asked_m_new);
    case (mid_cmd.op)
      OP_ANISO: val0_nxt = wa;
      OP_MIP:   val0_nxt = wm;
      default:  val0_nxt = mid_cmd.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pend_r <= 1'b0;
      aniso_pend_r <= 1'b0;
      mip_pend_r   <= 1'b0;
    end else if (mid_pop) begin
      first_pend_r <= (mid_cmd.op != OP_RESET);
      aniso_pend_r <= (mid_cmd.op == OP_MIN) && (wa != sent_aniso_r[e]);
      mip_pend_r   <= (mid_cmd.op == OP_MIN) && (wm != sent_mip_r[e]);
    end else if (res_push) begin
      if (first_pend_r) begin
        first_pend_r <= 1'b0;
      end else if (aniso_pend_r) begin
        aniso_pend_r <= 1'b0;
      end else begin
        mip_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      smp_r  <= mid_cmd.sampler;
      typ_r  <= mid_cmd.stype;
      val0_r <= val0_nxt;
      wa_r   <= wa;
      wm_r   <= wm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (mid_pop && mid_cmd.op == OP_RESET)) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        min_aniso_r[k]   <= 1'b0;
        asked_mip_r[k]   <= '0;
        asked_aniso_r[k] <= 32'd1;
        sent_mip_r[k]    <= '0;
        sent_aniso_r[k]  <= 32'd1;
      end
    end else if (mid_pop) begin
      case (mid_cmd.op)
        OP_ANISO: begin
          asked_aniso_r[e] <= mid_cmd.value;
          sent_aniso_r[e]  <= wa;
        end
        OP_MIP: begin
          asked_mip_r[e] <= mid_cmd.value;
          sent_mip_r[e]  <= wm;
        end
        OP_MIN: begin
          // Writing an unchanged value back to the sent copy is harmless.
          min_aniso_r[e]  <= min_new;
          sent_aniso_r[e] <= wa;
          sent_mip_r[e]   <= wm;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sampler_state_write_override_top.sv =====
// Top level of the sampler state write filter: front end, command queue, back end
// and result queue. Depends on sswo_pkg, sswo_fifo, sswo_front and sswo_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   input    | push / full           | in_cmd, in_sampler, in_state_type, in_value
//   result   | pop / empty           | out_sampler, out_type, out_value, out_last
//   config   | cfg_we                | cfg_index, cfg_data
//
// The back end takes one word per cycle from the command queue while each word yields
// one result and the result queue has room. A min-filter word holds it until all of its
// one to three results are pushed, and a device reset yields no result. The shadow table
// is rewritten in the cycle the word is taken. A result passes the command queue, the
// back-end result registers and the result queue on its way to the result ports. Reset
// is synchronous and empties both queues and the table; full and empty stall each side independently.
`default_nettype none

module sampler_state_write_override_top
  import sswo_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  in_cmd,
  input  wire logic [31:0]           in_sampler,
  input  wire logic [7:0]            in_state_type,
  input  wire logic [31:0]           in_value,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [31:0]                out_sampler,
  output logic [7:0]                 out_type,
  output logic [31:0]                out_value,
  output logic                       out_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  sswo_cmd_t front_cmd, mid_cmd;
  sswo_res_t back_res, out_res;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  logic      res_push, res_full;

  sswo_front u_front (
    .in_push       (push),
    .in_cmd        (in_cmd),
    .in_sampler    (in_sampler),
    .in_state_type (in_state_type),
    .in_value      (in_value),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_cmd       (front_cmd)
  );

  sswo_fifo #(
    .WIDTH ($bits(sswo_cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (front_cmd),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_cmd),
    .empty (mid_empty)
  );

  sswo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_empty (mid_empty),
    .mid_cmd   (mid_cmd),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  sswo_fifo #(
    .WIDTH ($bits(sswo_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign full        = mid_full;
  assign out_sampler = out_res.sampler;
  assign out_type    = out_res.stype;
  assign out_value   = out_res.value;
  assign out_last    = out_res.last;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("back end pushed a result into a full result queue");

  a_pop_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end took a word from an empty command queue");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ===== tb/tb_sampler_state_write_override_top.sv =====
// Self-checking testbench for sampler_state_write_override_top.
// A directed table and then random phases under several register settings, checked
// word by word against a shadow-table predictor. Depends on sswo_pkg and the top level.
`default_nettype none

module tb_sampler_state_write_override_top;
  import sswo_pkg::*;

  localparam int SETTLE_CYC  = 24;
  localparam int HOLD_CYC    = 300;
  localparam int WDOG_LIMIT  = 3000;
  localparam int PHASE_WORDS = 68;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // A row either sends one word or writes both registers (degree in val, trilinear in smp).
  typedef struct packed {
    row_kind_t        kind;
    logic             cmd;
    logic [31:0]      smp;
    logic [7:0]       typ;
    logic [31:0]      val;
    logic             known;
    logic [1:0]       n;
    sswo_res_t [2:0]  w;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  in_cmd = 1'b0;
  logic [31:0]           in_sampler = '0;
  logic [7:0]            in_state_type = '0;
  logic [31:0]           in_value = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [31:0]           out_sampler;
  logic [7:0]            out_type;
  logic [31:0]           out_value;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Expected writes typed into the table travel alongside the word being offered.
  logic            offer_known = 1'b0;
  logic [1:0]      offer_n = '0;
  sswo_res_t [2:0] offer_w = '0;

  sswo_res_t pending_writes[$];
  int        err_cnt = 0;
  int        idle_cycles = 0;
  bit        hold_rx = 1'b0;
  bit        no_idle = 1'b0;

  // Predictor copy of the registers and the shadow table.
  logic [31:0] cur_degree;
  logic        cur_tril;
  logic        shd_min_aniso [NUM_STAGES];
  logic [31:0] shd_ask_mip   [NUM_STAGES];
  logic [31:0] shd_ask_aniso [NUM_STAGES];
  logic [31:0] shd_sent_mip  [NUM_STAGES];
  logic [31:0] shd_sent_aniso[NUM_STAGES];

  dir_row_t    dir_tab[$];
  logic [4:0]  ph_deg [6];
  logic        ph_tril[6];

  sampler_state_write_override_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_cmd       (in_cmd),
    .in_sampler   (in_sampler),
    .in_state_type(in_state_type),
    .in_value     (in_value),
    .empty        (empty),
    .pop          (pop),
    .out_sampler  (out_sampler),
    .out_type     (out_type),
    .out_value    (out_value),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic sswo_res_t wr(logic [31:0] s, logic [7:0] t, logic [31:0] v, logic l);
    return '{sampler: s, stype: t, value: v, last: l};
  endfunction

  function automatic dir_row_t word_row(logic c, logic [31:0] s, logic [7:0] t,
                                        logic [31:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.cmd  = c;
    r.smp  = s;
    r.typ  = t;
    r.val  = v;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic c, logic [31:0] s, logic [7:0] t,
                                         logic [31:0] v, int n, sswo_res_t w0,
                                         sswo_res_t w1, sswo_res_t w2);
    dir_row_t r;
    r = word_row(c, s, t, v);
    r.known = 1'b1;
    r.n     = 2'(n);
    r.w[0]  = w0;
    r.w[1]  = w1;
    r.w[2]  = w2;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [4:0] deg, logic tril);
    dir_row_t r;
    r = '0;
    r.kind   = ROW_CFG;
    r.val    = {27'd0, deg};
    r.smp[0] = tril;
    return r;
  endfunction

  function automatic void clear_shadow();
    for (int k = 0; k < NUM_STAGES; k++) begin
      shd_min_aniso[k]  = 1'b0;
      shd_ask_mip[k]    = 32'd0;
      shd_ask_aniso[k]  = 32'd1;
      shd_sent_mip[k]   = 32'd0;
      shd_sent_aniso[k] = 32'd1;
    end
  endfunction

  function automatic int stage_of(logic [31:0] s);
    if (s < 32'd16) return int'(s);
    if (s == 32'd256) return 16;
    if (s >= 32'd257 && s <= 32'd260) return 17 + int'(s - 32'd257);
    return -1;
  endfunction

  function automatic logic [31:0] aniso_target(int e);
    if (cur_degree != 0 && shd_min_aniso[e] && cur_degree > shd_ask_aniso[e])
      return cur_degree;
    return shd_ask_aniso[e];
  endfunction

  function automatic logic [31:0] mip_target(int e);
    if (cur_tril && shd_min_aniso[e] && shd_ask_mip[e] == F_POINT) return F_LINEAR;
    return shd_ask_mip[e];
  endfunction

  // Works out the device writes caused by one accepted word and updates the shadow table.
  function automatic int predict_writes(logic c, logic [31:0] s, logic [7:0] t,
                                        logic [31:0] v, output sswo_res_t [2:0] w);
    int          e;
    int          n;
    logic [31:0] wa;
    logic [31:0] wm;
    w = '0;
    if (c) begin
      clear_shadow();
      return 0;
    end
    e = stage_of(s);
    n = 1;
    if (e < 0 || !(t == ST_MINFILTER || t == ST_MIPFILTER || t == ST_MAXANISO)) begin
      w[0] = wr(s, t, v, 1'b0);
    end else if (t == ST_MAXANISO) begin
      shd_ask_aniso[e] = v;
      wa = aniso_target(e);
      shd_sent_aniso[e] = wa;
      w[0] = wr(s, t, wa, 1'b0);
    end else if (t == ST_MIPFILTER) begin
      shd_ask_mip[e] = v;
      wm = mip_target(e);
      shd_sent_mip[e] = wm;
      w[0] = wr(s, t, wm, 1'b0);
    end else begin
      shd_min_aniso[e] = (v == F_ANISO);
      w[0] = wr(s, t, v, 1'b0);
      wa = aniso_target(e);
      wm = mip_target(e);
      if (wa != shd_sent_aniso[e]) begin
        w[n] = wr(s, ST_MAXANISO, wa, 1'b0);
        n++;
        shd_sent_aniso[e] = wa;
      end
      if (wm != shd_sent_mip[e]) begin
        w[n] = wr(s, ST_MIPFILTER, wm, 1'b0);
        n++;
        shd_sent_mip[e] = wm;
      end
    end
    w[n-1].last = 1'b1;
    return n;
  endfunction

  // Monitor: register writes, accepted words and accepted results, all sampled at the edge.
  always @(posedge clk) begin
    sswo_res_t       got;
    sswo_res_t       exp_w;
    sswo_res_t [2:0] w;
    int              n;
    if (!rst_n) begin
      clear_shadow();
      cur_degree = 32'd0;
      cur_tril   = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANISO_DEGREE: begin
            if (cfg_data == 5'd1) cur_degree = 32'd0;
            else if (cfg_data > 5'd16) cur_degree = 32'd16;
            else cur_degree = {27'd0, cfg_data};
          end
          REG_TRILINEAR: cur_tril = cfg_data[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got = wr(out_sampler, out_type, out_value, out_last);
        if (pending_writes.size() == 0) begin
          $error("unexpected result word: sampler %h type %h value %h last %b",
                 got.sampler, got.stype, got.value, got.last);
          err_cnt++;
        end else begin
          exp_w = pending_writes.pop_front();
          if (got.sampler !== exp_w.sampler) begin
            $error("out_sampler: expected %h, got %h", exp_w.sampler, got.sampler);
            err_cnt++;
          end
          if (got.stype !== exp_w.stype) begin
            $error("out_type: expected %h, got %h", exp_w.stype, got.stype);
            err_cnt++;
          end
          if (got.value !== exp_w.value) begin
            $error("out_value: expected %h, got %h", exp_w.value, got.value);
            err_cnt++;
          end
          if (got.last !== exp_w.last) begin
            $error("out_last: expected %b, got %b", exp_w.last, got.last);
            err_cnt++;
          end
        end
      end
      if (push && !full) begin
        n = predict_writes(in_cmd, in_sampler, in_state_type, in_value, w);
        if (offer_known) begin
          n = int'(offer_n);
          w = offer_w;
        end
        for (int k = 0; k < n; k++) pending_writes.push_back(w[k]);
      end
    end
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    while (idle_cycles < WDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none while no_idle is set.
  initial begin
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 30);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic c, logic [31:0] s, logic [7:0] t, logic [31:0] v,
                           logic known, logic [1:0] n, sswo_res_t [2:0] w);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push          <= 1'b1;
    in_cmd        <= c;
    in_sampler    <= s;
    in_state_type <= t;
    in_value      <= v;
    offer_known   <= known;
    offer_n       <= n;
    offer_w       <= w;
    do @(posedge clk); while (full);
  endtask

  // Stops offering, waits for every expected word, then lets trailing resets finish.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic [4:0] deg, logic tril);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ANISO_DEGREE;
    cfg_data  <= deg;
    @(posedge clk);
    cfg_index <= REG_TRILINEAR;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, tril};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic rand_word();
    logic        c;
    logic [31:0] s;
    logic [7:0]  t;
    logic [31:0] v;
    int          p;
    c = ($urandom_range(0, 99) < 3);
    p = $urandom_range(0, 99);
    // Two in five words hit stages 0 to 3 so that filter history builds up.
    if (p < 40) s = $urandom_range(0, 3);
    else if (p < 60) s = $urandom_range(0, 15);
    else if (p < 80) s = $urandom_range(256, 260);
    else if (p < 88) begin
      case ($urandom_range(0, 3))
        0: s = 32'd16;
        1: s = 32'd255;
        2: s = 32'd261;
        default: s = 32'hFFFF_FFFF;
      endcase
    end else s = $urandom;
    p = $urandom_range(0, 99);
    if (p < 35) t = ST_MINFILTER;
    else if (p < 60) t = ST_MIPFILTER;
    else if (p < 85) t = ST_MAXANISO;
    else t = 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (t == ST_MINFILTER) v = (p < 90) ? $urandom_range(0, 4) : $urandom;
    else if (t == ST_MIPFILTER) v = (p < 90) ? $urandom_range(0, 3) : $urandom;
    else if (t == ST_MAXANISO) v = (p < 85) ? $urandom_range(0, 20) : $urandom;
    else v = $urandom;
    if (c) begin
      s = $urandom;
      t = 8'($urandom_range(0, 255));
      v = $urandom;
    end
    send_word(c, s, t, v, 1'b0, 2'd0, '0);
  endtask

  initial begin
    dir_tab = '{
      known_row(1'b0, 32'd16, ST_MINFILTER, F_ANISO, 1,
                wr(32'd16, ST_MINFILTER, F_ANISO, 1'b1), '0, '0),
      known_row(1'b0, 32'd255, ST_MIPFILTER, F_POINT, 1,
                wr(32'd255, ST_MIPFILTER, F_POINT, 1'b1), '0, '0),
      known_row(1'b0, 32'd261, ST_MAXANISO, 32'd0, 1,
                wr(32'd261, ST_MAXANISO, 32'd0, 1'b1), '0, '0),
      known_row(1'b0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1,
                wr(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1), '0, '0),
      known_row(1'b0, 32'd5, 8'd0, 32'h1234_5678, 1,
                wr(32'd5, 8'd0, 32'h1234_5678, 1'b1), '0, '0),
      cfg_row(5'd31, 1'b1),
      known_row(1'b0, 32'd0, ST_MAXANISO, 32'd2, 1,
                wr(32'd0, ST_MAXANISO, 32'd2, 1'b1), '0, '0),
      known_row(1'b0, 32'd0, ST_MIPFILTER, F_POINT, 1,
                wr(32'd0, ST_MIPFILTER, F_POINT, 1'b1), '0, '0),
      // Going anisotropic re-sends both the raised degree and the upgraded mip filter.
      known_row(1'b0, 32'd0, ST_MINFILTER, F_ANISO, 3,
                wr(32'd0, ST_MINFILTER, F_ANISO, 1'b0),
                wr(32'd0, ST_MAXANISO, 32'd16, 1'b0),
                wr(32'd0, ST_MIPFILTER, F_LINEAR, 1'b1)),
      known_row(1'b0, 32'd0, ST_MAXANISO, 32'd4, 1,
                wr(32'd0, ST_MAXANISO, 32'd16, 1'b1), '0, '0),
      known_row(1'b0, 32'd0, ST_MAXANISO, 32'hFFFF_FFFF, 1,
                wr(32'd0, ST_MAXANISO, 32'hFFFF_FFFF, 1'b1), '0, '0),
      known_row(1'b0, 32'd0, ST_MINFILTER, F_LINEAR, 2,
                wr(32'd0, ST_MINFILTER, F_LINEAR, 1'b0),
                wr(32'd0, ST_MIPFILTER, F_POINT, 1'b1), '0),
      word_row(1'b0, 32'd256, ST_MINFILTER, F_ANISO),
      word_row(1'b0, 32'd256, ST_MAXANISO, 32'd5),
      word_row(1'b0, 32'd260, ST_MIPFILTER, F_POINT),
      word_row(1'b0, 32'd257, ST_MINFILTER, F_ANISO),
      word_row(1'b0, 32'd15, ST_MINFILTER, F_ANISO),
      known_row(1'b1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, '0, '0, '0),
      known_row(1'b0, 32'd0, ST_MINFILTER, F_ANISO, 2,
                wr(32'd0, ST_MINFILTER, F_ANISO, 1'b0),
                wr(32'd0, ST_MAXANISO, 32'd16, 1'b1), '0),
      cfg_row(5'd1, 1'b0),
      known_row(1'b0, 32'd0, ST_MAXANISO, 32'd0, 1,
                wr(32'd0, ST_MAXANISO, 32'd0, 1'b1), '0, '0),
      known_row(1'b0, 32'd0, ST_MIPFILTER, F_POINT, 1,
                wr(32'd0, ST_MIPFILTER, F_POINT, 1'b1), '0, '0),
      cfg_row(5'd17, 1'b0),
      word_row(1'b0, 32'd3, ST_MINFILTER, F_ANISO),
      word_row(1'b0, 32'd3, ST_MAXANISO, 32'd0),
      word_row(1'b0, 32'd3, ST_MINFILTER, F_POINT)
    };
    ph_deg  = '{5'd0, 5'd2, 5'd16, 5'd31, 5'($urandom_range(0, 31)), 5'd1};
    ph_tril = '{1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_cfg(dir_tab[i].val[4:0], dir_tab[i].smp[0]);
      else send_word(dir_tab[i].cmd, dir_tab[i].smp, dir_tab[i].typ, dir_tab[i].val,
                     dir_tab[i].known, dir_tab[i].n, dir_tab[i].w);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(ph_deg[ph], ph_tril[ph]);
      // One phase runs against a stalled receiver so the block fills and pushes back.
      if (ph == 1) hold_rx = 1'b1;
      no_idle = (ph == 3);
      repeat (PHASE_WORDS) rand_word();
    end
    no_idle = 1'b0;

    settle();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sswo_pkg.sv
hdl/sswo_fifo.sv
hdl/sswo_front.sv
hdl/sswo_back.sv
hdl/sampler_state_write_override_top.sv
tb/tb_sampler_state_write_override_top.sv
